### src/bbse_pkg.sv
`timescale 1ns / 1ps
// bbse_pkg: shared types and codes for the bounded byte stack engine
// command and result beat structs, op, status and register index codes
// no dependencies

package bbse_pkg;

    // op codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    // configuration register indexes
    localparam logic REG_STACK_START = 1'b0;
    localparam logic REG_STACK_LIMIT = 1'b1;

    // register reset values
    localparam logic [15:0] STACK_START_RST = 16'hFFFF;
    localparam logic [15:0] STACK_LIMIT_RST = 16'h0000;

    // command beat
    typedef struct packed {
        logic        op;
        logic [1:0]  size_code;
        logic [63:0] push_value;
    } cmd_t;

    // result beat
    typedef struct packed {
        logic [63:0] pop_value;
        logic [1:0]  status;
        logic [15:0] pointer_after;
    } res_t;

endpackage

### src/bounded_byte_stack_engine.sv
`timescale 1ns / 1ps
// bounded_byte_stack_engine: descending byte stack with bounds checks in a byte RAM
// depends on bbse_pkg for the command and result beat types and codes

// A command is taken when start is high and busy is low. A push of N bytes
// (N = 1, 2, 4 or 8) stores one byte a cycle through the single port of the
// byte-wide RAM and returns its result once the last byte is written; a pop
// reads one byte a cycle, waits on the registered RAM read for the last byte,
// and then returns its result. A push that would overflow or a pop that would
// underflow touches nothing and returns its result in the cycle after the
// command. Each result is shown for exactly one cycle with done high and
// cannot be held off, so it must be captured on that cycle. busy falls as done
// rises, so the next command may be given while a result is being shown.
// There is no clearing pass after reset: stack bytes read back are only those
// written by earlier pushes.

module bounded_byte_stack_engine #(
    parameter int MEM_BYTES = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               start,
    output logic               busy,
    input  bbse_pkg::cmd_t     cmd,
    // result channel
    output logic               done,
    output bbse_pkg::res_t     result,
    // configuration write port
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [15:0]        wr_data
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);
    // ram address of pointer value 0xffff
    localparam logic [AW-1:0] TOP_ADDR  = AW'(65535 % MEM_BYTES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PUSH = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [7:0]      mem [MEM_BYTES];

    logic [1:0]      state_reg, state_next;
    logic [15:0]     sp_reg, sp_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic [63:0]     data_reg, data_next;
    logic            pend_reg, pend_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    bbse_pkg::res_t  res_reg, res_next;
    logic [15:0]     start_reg;
    logic [15:0]     limit_reg;
    logic [7:0]      rd_data_reg;

    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   mem_addr;
    logic [7:0]      mem_wdata;

    logic [3:0]      size_n;
    logic [15:0]     sp_dn, sp_up;
    logic [AW-1:0]   addr_dn, addr_up;
    logic [63:0]     acc;
    logic            push_fail, pop_fail;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= bbse_pkg::STACK_START_RST;
            limit_reg <= bbse_pkg::STACK_LIMIT_RST;
        end
        else if (wr_en)
        begin
            if (wr_index == bbse_pkg::REG_STACK_START)
            begin
                start_reg <= wr_data;
            end
            else
            begin
                limit_reg <= wr_data;
            end
        end
    end

    // byte ram, one access a cycle, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // pointer steps with ram address kept in step, wrapping both ways
    always_comb
    begin
        sp_dn   = sp_reg - 16'd1;
        sp_up   = sp_reg + 16'd1;
        if (sp_reg == 16'h0000)
        begin
            addr_dn = TOP_ADDR;
        end
        else
        begin
            addr_dn = (addr_reg == '0) ? LAST_ADDR : addr_reg - AW'(1);
        end
        if (sp_reg == 16'hFFFF)
        begin
            addr_up = '0;
        end
        else
        begin
            addr_up = (addr_reg == LAST_ADDR) ? '0 : addr_reg + AW'(1);
        end
    end

    // bounds checks on the incoming command
    always_comb
    begin
        size_n    = 4'd1 << cmd.size_code;
        push_fail = {1'b0, sp_reg} < ({1'b0, limit_reg} + 17'(size_n) - 17'd1);
        pop_fail  = ({1'b0, sp_reg} + 17'(size_n)) > {1'b0, start_reg};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        sp_next    = sp_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        data_next  = data_reg;
        pend_next  = 1'b0;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = addr_reg;
        mem_wdata  = data_reg[7:0];
        acc        = pend_reg ? {data_reg[55:0], rd_data_reg} : data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.op == bbse_pkg::OP_PUSH)
                    begin
                        if (push_fail)
                        begin
                            done_next = 1'b1;
                            res_next  = '{pop_value: 64'd0,
                                          status: bbse_pkg::STATUS_OVERFLOW,
                                          pointer_after: sp_reg};
                        end
                        else
                        begin
                            state_next = S_PUSH;
                            cnt_next   = size_n;
                            data_next  = cmd.push_value;
                            busy_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        if (pop_fail)
                        begin
                            done_next = 1'b1;
                            res_next  = '{pop_value: 64'd0,
                                          status: bbse_pkg::STATUS_UNDERFLOW,
                                          pointer_after: sp_reg};
                        end
                        else
                        begin
                            state_next = S_POP;
                            cnt_next   = size_n;
                            data_next  = 64'd0;
                            busy_next  = 1'b1;
                        end
                    end
                end
            end

            // store low byte at the pointer, walk down
            S_PUSH:
            begin
                mem_we    = 1'b1;
                data_next = {8'd0, data_reg[63:8]};
                sp_next   = sp_dn;
                addr_next = addr_dn;
                cnt_next  = cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    res_next   = '{pop_value: 64'd0,
                                   status: bbse_pkg::STATUS_OK,
                                   pointer_after: sp_dn};
                end
            end

            // read upward from above the pointer, shift each byte in
            S_POP:
            begin
                data_next = acc;
                if (cnt_reg != 4'd0)
                begin
                    mem_re    = 1'b1;
                    mem_addr  = addr_up;
                    sp_next   = sp_up;
                    addr_next = addr_up;
                    cnt_next  = cnt_reg - 4'd1;
                    pend_next = 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                    busy_next  = 1'b0;
                    done_next  = 1'b1;
                    res_next   = '{pop_value: acc,
                                   status: bbse_pkg::STATUS_OK,
                                   pointer_after: sp_reg};
                end
            end

            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= bbse_pkg::STACK_START_RST;
            addr_reg  <= TOP_ADDR;
            cnt_reg   <= 4'd0;
            pend_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        res_reg  <= res_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = res_reg;

endmodule
